/* design/pidc_pkg.sv */
`default_nettype none

package pidc_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int SUM_WIDTH       = 48;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int GAIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 31;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 31;
	localparam int PROD_WIDTH      = SUM_WIDTH + GAIN_WIDTH;
	localparam int WIDE_WIDTH      = DATA_WIDTH + 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [SUM_WIDTH-1:0]  sum_t;
	typedef logic signed [GAIN_WIDTH-1:0] gain_t;
	typedef logic        [LIMIT_WIDTH-1:0] limit_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [WIDE_WIDTH-1:0] wide_t;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P    = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I    = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D    = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_INTEG = CFG_INDEX_WIDTH'(3);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DRIVE = CFG_INDEX_WIDTH'(4);

	localparam gain_t  GAIN_P_RESET    = GAIN_WIDTH'(7680);
	localparam gain_t  GAIN_I_RESET    = '0;
	localparam gain_t  GAIN_D_RESET    = '0;
	localparam limit_t MAX_INTEG_RESET = LIMIT_WIDTH'(13107200);
	localparam limit_t MAX_DRIVE_RESET = LIMIT_WIDTH'(183500800);

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Saturates a value two bits wider than the data path.
	function automatic data_t sat_data(input wide_t v);
		logic ovf;
		ovf = (v[WIDE_WIDTH-1:DATA_WIDTH-1] != {(WIDE_WIDTH-DATA_WIDTH+1){1'b0}}) &&
		      (v[WIDE_WIDTH-1:DATA_WIDTH-1] != {(WIDE_WIDTH-DATA_WIDTH+1){1'b1}});
		if (ovf) begin
			return v[WIDE_WIDTH-1] ? DATA_MIN : DATA_MAX;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	// Drops the gain fraction bits (floor) and saturates to the data width.
	function automatic data_t scale_sat(input prod_t p);
		prod_t q;
		logic  ovf;
		q   = p >>> GAIN_FRAC_BITS;
		ovf = (q[PROD_WIDTH-1:DATA_WIDTH-1] != {(PROD_WIDTH-DATA_WIDTH+1){1'b0}}) &&
		      (q[PROD_WIDTH-1:DATA_WIDTH-1] != {(PROD_WIDTH-DATA_WIDTH+1){1'b1}});
		if (ovf) begin
			return q[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
		end
		return q[DATA_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/pidc_if.sv */
`default_nettype none

interface pidc_sample_if;
	import pidc_pkg::*;
	logic  valid;
	logic  ready;
	data_t setpoint;
	data_t measured;
	modport source (output valid, output setpoint, output measured, input ready);
	modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pidc_result_if;
	import pidc_pkg::*;
	logic  valid;
	logic  ready;
	data_t drive;
	logic  integral_limited;
	logic  drive_limited;
	modport source (output valid, output drive, output integral_limited,
		output drive_limited, input ready);
	modport sink (input valid, input drive, input integral_limited,
		input drive_limited, output ready);
endinterface

`default_nettype wire

/* design/positional_pid_with_clamps_unit.sv */
// An accepted sample word passes stages 1 to 3 and the output register.
// Throughput: one word per cycle while result.ready does not stall; the error
// sum and previous error are updated in the second stage, so consecutive
// words need no gap. Each stage holds its word until the next stage can take it.
// Reset clears the error sum, the previous error and all valid flags, and
// returns the gains and limits to their reset values.
`default_nettype none

module positional_pid_with_clamps_unit
	import pidc_pkg::*;
(
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [CFG_INDEX_WIDTH-1:0]      cfg_index,
	input  wire  [CFG_DATA_WIDTH-1:0]       cfg_data,
	pidc_sample_if.sink                     sample,
	pidc_result_if.source                   result
);

	gain_t  gain_p_q, gain_i_q, gain_d_q;
	limit_t max_integ_q, max_drive_q;

	data_t prev_err_q;
	sum_t  err_sum_q;

	logic  v_s1, v_s2, v_s3, v_q;
	data_t sp_s1, ms_s1;
	data_t err_s2, diff_s2;
	sum_t  sum_s2;
	data_t pterm_s3, iterm_s3, dterm_s3;
	data_t drive_q;
	logic  ilim_q, dlim_q;

	logic adv_q, adv_s3, adv_s2, adv_s1;

	assign adv_q  = !v_q || result.ready;
	assign adv_s3 = !v_s3 || adv_q;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_P_RESET;
			gain_i_q    <= GAIN_I_RESET;
			gain_d_q    <= GAIN_D_RESET;
			max_integ_q <= MAX_INTEG_RESET;
			max_drive_q <= MAX_DRIVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    gain_p_q    <= cfg_data[GAIN_WIDTH-1:0];
				REG_GAIN_I:    gain_i_q    <= cfg_data[GAIN_WIDTH-1:0];
				REG_GAIN_D:    gain_d_q    <= cfg_data[GAIN_WIDTH-1:0];
				REG_MAX_INTEG: max_integ_q <= cfg_data[LIMIT_WIDTH-1:0];
				REG_MAX_DRIVE: max_drive_q <= cfg_data[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: sample register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			sp_s1 <= sample.setpoint;
			ms_s1 <= sample.measured;
		end
	end

	// Stage 2: error, difference and the saturating error sum.
	data_t                err_w, diff_w;
	logic signed [SUM_WIDTH:0] sum_wide_w;
	sum_t                 sum_w;

	always_comb begin
		err_w  = sat_data(WIDE_WIDTH'(sp_s1) - WIDE_WIDTH'(ms_s1));
		diff_w = sat_data(WIDE_WIDTH'(err_w) - WIDE_WIDTH'(prev_err_q));
		sum_wide_w = (SUM_WIDTH+1)'(err_sum_q) + (SUM_WIDTH+1)'(err_w);
		if (sum_wide_w[SUM_WIDTH] != sum_wide_w[SUM_WIDTH-1]) begin
			sum_w = sum_wide_w[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
			                              : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_w = sum_wide_w[SUM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			prev_err_q <= '0;
			err_sum_q  <= '0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				prev_err_q <= err_w;
				err_sum_q  <= sum_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			err_s2  <= err_w;
			diff_s2 <= diff_w;
			sum_s2  <= sum_w;
		end
	end

	// Stage 3: the three gain products.
	logic signed [DATA_WIDTH+GAIN_WIDTH-1:0] prod_p_w, prod_d_w;
	prod_t                                   prod_i_w;

	assign prod_p_w = err_s2 * gain_p_q;
	assign prod_d_w = diff_s2 * gain_d_q;
	assign prod_i_w = sum_s2 * gain_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			pterm_s3 <= scale_sat(PROD_WIDTH'(prod_p_w));
			iterm_s3 <= scale_sat(prod_i_w);
			dterm_s3 <= scale_sat(PROD_WIDTH'(prod_d_w));
		end
	end

	// Output stage: integral clamp, sum of terms and drive clamp.
	wide_t iterm_w, ilim_pos_w, dlim_pos_w, total_w, total_clamp_w;
	data_t drive_w;
	logic  ilim_w, dlim_w;

	always_comb begin
		ilim_pos_w = WIDE_WIDTH'(max_integ_q);
		dlim_pos_w = WIDE_WIDTH'(max_drive_q);
		iterm_w    = WIDE_WIDTH'(iterm_s3);
		ilim_w     = 1'b0;
		if (iterm_w > ilim_pos_w) begin
			iterm_w = ilim_pos_w;
			ilim_w  = 1'b1;
		end else if (iterm_w < -ilim_pos_w) begin
			iterm_w = -ilim_pos_w;
			ilim_w  = 1'b1;
		end
		total_w       = WIDE_WIDTH'(pterm_s3) + iterm_w + WIDE_WIDTH'(dterm_s3);
		total_clamp_w = total_w;
		dlim_w        = 1'b0;
		if (total_w > dlim_pos_w) begin
			total_clamp_w = dlim_pos_w;
			dlim_w        = 1'b1;
		end else if (total_w < -dlim_pos_w) begin
			total_clamp_w = -dlim_pos_w;
			dlim_w        = 1'b1;
		end
		drive_w = sat_data(total_clamp_w);
		if (WIDE_WIDTH'(drive_w) != total_clamp_w) begin
			dlim_w = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv_q) begin
			v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_q && v_s3) begin
			drive_q <= drive_w;
			ilim_q  <= ilim_w;
			dlim_q  <= dlim_w;
		end
	end

	assign result.valid            = v_q;
	assign result.drive            = drive_q;
	assign result.integral_limited = ilim_q;
	assign result.drive_limited    = dlim_q;

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	localparam int     CYCLE_LIMIT = 1_500_000;
	localparam int     PHASE_ITEMS = 200;
	localparam longint SUM_TOP     = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_BOTTOM  = -SUM_TOP - 1;
	localparam gain_t  GAIN_TOP    = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
	localparam gain_t  GAIN_BOTTOM = {1'b1, {(GAIN_WIDTH-1){1'b0}}};
	localparam gain_t  GAIN_UNITY  = gain_t'(1 << GAIN_FRAC_BITS);
	localparam limit_t LIMIT_TOP   = '1;
	localparam int     FIRST_UNUSED_REG = int'(REG_MAX_DRIVE) + 1;
	localparam int     LAST_REG_INDEX   = (1 << CFG_INDEX_WIDTH) - 1;

	typedef struct packed {
		data_t drive;
		logic  integ_flag;
		logic  drive_flag;
	} drive_word_t;

	typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_LONG} rx_style_t;

	class drive_scoreboard;
		gain_t       kp;
		gain_t       ki;
		gain_t       kd;
		limit_t      integ_limit;
		limit_t      drive_limit;
		longint      prev_err;
		longint      err_sum;
		drive_word_t pending[$];
		int          errors;

		function new();
			kp          = GAIN_P_RESET;
			ki          = GAIN_I_RESET;
			kd          = GAIN_D_RESET;
			integ_limit = MAX_INTEG_RESET;
			drive_limit = MAX_DRIVE_RESET;
			prev_err    = 0;
			err_sum     = 0;
			errors      = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
			logic [CFG_DATA_WIDTH-1:0] value);
			case (idx)
				REG_GAIN_P:    kp = gain_t'(value[GAIN_WIDTH-1:0]);
				REG_GAIN_I:    ki = gain_t'(value[GAIN_WIDTH-1:0]);
				REG_GAIN_D:    kd = gain_t'(value[GAIN_WIDTH-1:0]);
				REG_MAX_INTEG: integ_limit = value[LIMIT_WIDTH-1:0];
				REG_MAX_DRIVE: drive_limit = value[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function longint clip_data(longint v);
			if (v > longint'(DATA_MAX)) begin
				return longint'(DATA_MAX);
			end
			if (v < longint'(DATA_MIN)) begin
				return longint'(DATA_MIN);
			end
			return v;
		endfunction

		// Arithmetic shift gives the floor of the scaled product.
		function longint scaled_product(longint a, gain_t g);
			longint p;
			p = a * longint'(g);
			return clip_data(p >>> GAIN_FRAC_BITS);
		endfunction

		function drive_word_t predict_drive(data_t sp, data_t ms);
			longint      err;
			longint      diff;
			longint      pterm;
			longint      iterm;
			longint      dterm;
			longint      total;
			drive_word_t w;
			err  = clip_data(longint'(sp) - longint'(ms));
			diff = clip_data(err - prev_err);
			if (err > 0 && err_sum > SUM_TOP - err) begin
				err_sum = SUM_TOP;
			end else if (err < 0 && err_sum < SUM_BOTTOM - err) begin
				err_sum = SUM_BOTTOM;
			end else begin
				err_sum = err_sum + err;
			end
			prev_err = err;
			pterm = scaled_product(err, kp);
			iterm = scaled_product(err_sum, ki);
			dterm = scaled_product(diff, kd);
			w.integ_flag = 1'b0;
			w.drive_flag = 1'b0;
			if (iterm > longint'(integ_limit)) begin
				iterm = longint'(integ_limit);
				w.integ_flag = 1'b1;
			end else if (iterm < -longint'(integ_limit)) begin
				iterm = -longint'(integ_limit);
				w.integ_flag = 1'b1;
			end
			total = pterm + iterm + dterm;
			if (total > longint'(drive_limit)) begin
				total = longint'(drive_limit);
				w.drive_flag = 1'b1;
			end else if (total < -longint'(drive_limit)) begin
				total = -longint'(drive_limit);
				w.drive_flag = 1'b1;
			end
			if (clip_data(total) != total) begin
				total = clip_data(total);
				w.drive_flag = 1'b1;
			end
			w.drive = data_t'(total);
			return w;
		endfunction

		function void note_sample(data_t sp, data_t ms);
			pending.push_back(predict_drive(sp, ms));
		endfunction

		function void report(string what, longint want, longint got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_word(drive_word_t got);
			drive_word_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual drive %0d",
					$time, got.drive);
				return;
			end
			want = pending.pop_front();
			if (got.drive !== want.drive) begin
				report("drive", longint'(want.drive), longint'(got.drive));
			end
			if (got.integ_flag !== want.integ_flag) begin
				report("integral_limited", longint'(want.integ_flag), longint'(got.integ_flag));
			end
			if (got.drive_flag !== want.drive_flag) begin
				report("drive_limited", longint'(want.drive_flag), longint'(got.drive_flag));
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	rx_style_t                  rx_mode;
	int                         rx_tick;
	int                         stall_left;
	int                         cycle_count;
	drive_word_t                seen_word;
	drive_scoreboard            sb;

	pidc_sample_if sample();
	pidc_result_if result();

	positional_pid_with_clamps_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		case (rx_mode)
			RX_OPEN: result.ready <= 1'b1;
			RX_COIN: result.ready <= ($urandom_range(1, 0) != 0);
			RX_COMB: result.ready <= ((rx_tick % 8) >= 3);
			default: begin
				if (stall_left > 0) begin
					result.ready <= 1'b0;
					stall_left--;
				end else begin
					result.ready <= 1'b1;
					if ($urandom_range(9, 0) == 0) begin
						stall_left = $urandom_range(20, 1);
					end
				end
			end
		endcase
		rx_tick++;
	end

	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			seen_word.drive      = result.drive;
			seen_word.integ_flag = result.integral_limited;
			seen_word.drive_flag = result.drive_limited;
			sb.check_word(seen_word);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic offer_sample(input data_t sp, input data_t ms);
		@(negedge clk);
		sample.valid    <= 1'b1;
		sample.setpoint <= sp;
		sample.measured <= ms;
		@(posedge clk);
		while (sample.ready !== 1'b1) begin
			@(posedge clk);
		end
		sb.note_sample(sp, ms);
	endtask

	task automatic pause_sender(input int gap);
		@(negedge clk);
		sample.valid    <= 1'b0;
		sample.setpoint <= data_t'($urandom);
		sample.measured <= data_t'($urandom);
		repeat (gap - 1) @(negedge clk);
	endtask

	task automatic settle_block();
		@(negedge clk);
		sample.valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic program_register(input int idx, input logic [CFG_DATA_WIDTH-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INDEX_WIDTH'(idx);
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_register(CFG_INDEX_WIDTH'(idx), value);
	endtask

	task automatic program_all(input gain_t kp, input gain_t ki, input gain_t kd,
		input limit_t integ_limit, input limit_t drive_limit);
		int i;
		program_register(REG_GAIN_P, {(CFG_DATA_WIDTH-GAIN_WIDTH)'($urandom), kp});
		program_register(REG_GAIN_I, {(CFG_DATA_WIDTH-GAIN_WIDTH)'($urandom), ki});
		program_register(REG_GAIN_D, {(CFG_DATA_WIDTH-GAIN_WIDTH)'($urandom), kd});
		program_register(REG_MAX_INTEG, integ_limit);
		program_register(REG_MAX_DRIVE, drive_limit);
		for (i = FIRST_UNUSED_REG; i <= LAST_REG_INDEX; i++) begin
			program_register(i, CFG_DATA_WIDTH'($urandom));
		end
	endtask

	function automatic gain_t pick_gain();
		case ($urandom_range(3, 0))
			0: return GAIN_TOP;
			1: return GAIN_BOTTOM;
			2: return gain_t'($urandom);
			default: return gain_t'(int'($urandom_range(2048, 0)) - 1024);
		endcase
	endfunction

	function automatic limit_t pick_limit();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return LIMIT_TOP;
			2: return limit_t'($urandom);
			default: return limit_t'($urandom_range(1 << 24, 0));
		endcase
	endfunction

	task automatic randomize_registers();
		program_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
	endtask

	function automatic data_t pick_corner();
		case ($urandom_range(4, 0))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2: return '0;
			3: return '1;
			default: return data_t'(1);
		endcase
	endfunction

	task automatic pick_sample(output data_t sp, output data_t ms);
		case ($urandom_range(9, 0))
			0, 1, 2, 3: begin
				sp = data_t'($urandom);
				ms = sp - data_t'(int'($urandom_range(4095, 0)) - 2048);
			end
			4, 5, 6: begin
				sp = data_t'($urandom);
				ms = data_t'($urandom);
			end
			7: begin
				sp = pick_corner();
				ms = pick_corner();
			end
			default: begin
				sp = data_t'(int'($urandom_range((1 << 20) - 1, 0)) - (1 << 19));
				ms = data_t'(int'($urandom_range((1 << 20) - 1, 0)) - (1 << 19));
			end
		endcase
	endtask

	task automatic run_random_phase(input int count);
		int    k;
		int    burst_left;
		data_t sp;
		data_t ms;
		burst_left = 0;
		rx_mode = rx_style_t'($urandom_range(3, 0));
		for (k = 0; k < count; k++) begin
			if (k == count / 2) begin
				settle_block();
				rx_mode = rx_style_t'($urandom_range(3, 0));
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(24, 1);
				if ($urandom_range(3, 0) != 0) begin
					pause_sender($urandom_range(8, 1));
				end
			end
			pick_sample(sp, ms);
			offer_sample(sp, ms);
			burst_left--;
		end
		settle_block();
	endtask

	initial begin
		int    p;
		data_t unit_one;
		sb              = new();
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		sample.valid    = 1'b0;
		sample.setpoint = '0;
		sample.measured = '0;
		result.ready    = 1'b0;
		rx_mode         = RX_COIN;
		rx_tick         = 0;
		stall_left      = 0;
		unit_one        = data_t'(1 << 16);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a large error runs into the output clamp.
		offer_sample(data_t'(100 << 16), '0);
		offer_sample(unit_one, '0);
		offer_sample('0, unit_one);
		settle_block();

		// Output clamp exactly at and just past the limit, both signs.
		program_all(GAIN_UNITY, '0, '0, MAX_INTEG_RESET, limit_t'(1000));
		offer_sample(data_t'(1000), '0);
		offer_sample(data_t'(1001), '0);
		offer_sample(data_t'(-1000), '0);
		offer_sample(data_t'(-1001), '0);
		settle_block();

		// Integral clamp exactly at and just past the limit, both signs.
		program_all('0, GAIN_UNITY, '0, limit_t'(5000), LIMIT_TOP);
		offer_sample(data_t'(5000 - sb.err_sum), '0);
		offer_sample(data_t'(5001 - sb.err_sum), '0);
		offer_sample(data_t'(-5000 - sb.err_sum), '0);
		offer_sample(data_t'(-5001 - sb.err_sum), '0);
		settle_block();

		// Field extremes: error and difference saturation, product saturation.
		program_all(GAIN_TOP, GAIN_TOP, GAIN_BOTTOM, LIMIT_TOP, LIMIT_TOP);
		offer_sample(DATA_MAX, DATA_MIN);
		offer_sample(DATA_MIN, DATA_MAX);
		offer_sample('0, '0);
		offer_sample(DATA_MAX, '0);
		offer_sample(DATA_MIN, '0);
		offer_sample('0, DATA_MIN);
		offer_sample('1, '0);
		offer_sample(data_t'(1), '0);
		settle_block();

		program_all(GAIN_BOTTOM, GAIN_TOP, GAIN_TOP, '0, LIMIT_TOP);
		run_random_phase(PHASE_ITEMS);
		program_all(GAIN_TOP, GAIN_BOTTOM, GAIN_BOTTOM, LIMIT_TOP, '0);
		run_random_phase(PHASE_ITEMS);
		for (p = 0; p < 3; p++) begin
			randomize_registers();
			run_random_phase(PHASE_ITEMS);
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
